### hdl/assert_macros.svh
// assertion macros for the allocator rtl
// expects i_clk and i_rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define INA_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("allocator check failed");

// antecedent implies consequent in the same cycle
`define INA_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("allocator check failed");

`endif

### hdl/ina_pkg.sv
// types, opcodes and constants of the interval name allocator
// no dependencies
package ina_pkg;

    localparam int MAX_RANGES_DEF = 16;
    localparam int MAX_BATCH_DEF  = 64;
    localparam int NAME_W         = 32;
    localparam int COUNT_W        = 7;
    localparam int CMD_W          = 2;
    localparam int OP_W           = 4;

    localparam logic [CMD_W-1:0] CMD_GEN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_VAL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;

    localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
    localparam logic [OP_W-1:0] OP_GSTART = 4'd1;
    localparam logic [OP_W-1:0] OP_GSTEP  = 4'd2;
    localparam logic [OP_W-1:0] OP_GEXT   = 4'd3;
    localparam logic [OP_W-1:0] OP_GMERGE = 4'd4;
    localparam logic [OP_W-1:0] OP_LOCATE = 4'd5;
    localparam logic [OP_W-1:0] OP_DREM   = 4'd6;
    localparam logic [OP_W-1:0] OP_DINC   = 4'd7;
    localparam logic [OP_W-1:0] OP_DDEC   = 4'd8;
    localparam logic [OP_W-1:0] OP_DSPLIT = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COUNT_W-1:0] n;
        logic [NAME_W-1:0]  nm;
    } t_bcast;

    typedef struct packed {
        logic              vld;
        logic              tok;
        logic              evt;
        logic [NAME_W-1:0] first;
        logic [NAME_W-1:0] final_nm;
    } t_link;

    typedef struct packed {
        logic              tok;
        logic              hit;
        logic              wrap;
        logic              merge;
        logic              single;
        logic              at_first;
        logic              at_final;
        logic [NAME_W-1:0] fin;
    } t_rpt;

endpackage

### hdl/interval_name_allocator.sv
// Interval name allocator: allocated 32-bit names live as sorted ranges, one range per cell
// of a chain of MAX_RANGES cells; one command is in flight at a time. Validate passes the
// locate step and ST_VRPT, delete the locate step, ST_DRPT and ST_DAPP, before the result
// item is offered. Generate walks a token down the chain one cell per cycle to the range
// that grows, then offers one item per cycle while i_ready is high, one per count name.
// depends on ina_pkg, ina_cell and assert_macros.svh
`include "assert_macros.svh"
module interval_name_allocator import ina_pkg::*; #(
    parameter int MAX_RANGES = MAX_RANGES_DEF,
    parameter int MAX_BATCH  = MAX_BATCH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [COUNT_W-1:0] i_count,
    input  logic [NAME_W-1:0]  i_name,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [NAME_W-1:0]  o_name_out,
    output logic               o_ok,
    output logic               o_found,
    output logic               o_last
);

    localparam int CNT_W = $clog2(MAX_RANGES + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_GAPP = 3'd2;
    localparam logic [2:0] ST_DRPT = 3'd3;
    localparam logic [2:0] ST_DAPP = 3'd4;
    localparam logic [2:0] ST_VRPT = 3'd5;
    localparam logic [2:0] ST_OUTW = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [COUNT_W-1:0] r_n, n_n;
    logic [COUNT_W-1:0] r_left, n_left;
    logic [NAME_W-1:0]  r_nm, n_nm;
    logic [NAME_W-1:0]  r_base, n_base;
    logic               r_merge, n_merge;
    logic [OP_W-1:0]    r_dop, n_dop;
    logic               r_dfail, n_dfail;
    logic               r_ovld, n_ovld;
    logic [NAME_W-1:0]  r_oname, n_oname;
    logic               r_ook, n_ook;
    logic               r_ofnd, n_ofnd;
    logic               r_olast, n_olast;

    t_bcast w_bc;
    t_link  w_lnk [MAX_RANGES];
    t_rpt   w_rpt [MAX_RANGES];
    t_rpt   w_any;
    logic [MAX_RANGES-1:0] w_toks;

    genvar g;
    generate
        for (g = 0; g < MAX_RANGES; g++) begin : g_cell
            t_link w_l, w_r;
            if (g == 0) begin : g_l0
                assign w_l = '0;
            end else begin : g_ln
                assign w_l = w_lnk[g-1];
            end
            if (g == MAX_RANGES - 1) begin : g_r0
                assign w_r = '0;
            end else begin : g_rn
                assign w_r = w_lnk[g+1];
            end
            ina_cell #(.P_HEAD(g == 0)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_bc    (w_bc),
                .i_left  (w_l),
                .i_right (w_r),
                .o_link  (w_lnk[g]),
                .o_rpt   (w_rpt[g])
            );
            assign w_toks[g] = w_lnk[g].tok;
        end
    endgenerate

    always_comb begin
        w_any = '0;
        for (int i = 0; i < MAX_RANGES; i++) begin
            w_any = t_rpt'(w_any | w_rpt[i]);
        end
    end

    assign o_ready    = (r_state == ST_IDLE) && !r_ovld;
    assign o_valid    = r_ovld;
    assign o_name_out = r_oname;
    assign o_ok       = r_ook;
    assign o_found    = r_ofnd;
    assign o_last     = r_olast;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_left  = r_left;
        n_nm    = r_nm;
        n_base  = r_base;
        n_merge = r_merge;
        n_dop   = r_dop;
        n_dfail = r_dfail;
        n_ovld  = r_ovld;
        n_oname = r_oname;
        n_ook   = r_ook;
        n_ofnd  = r_ofnd;
        n_olast = r_olast;
        w_bc    = '{op: OP_NONE, n: r_n, nm: r_nm};
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    n_n     = i_count;
                    n_nm    = i_name;
                    n_oname = '0;
                    n_ook   = 1'b1;
                    n_ofnd  = 1'b0;
                    n_olast = 1'b1;
                    unique case (i_cmd)
                        CMD_GEN: begin
                            if (i_count == '0) begin
                                n_ovld  = 1'b1;
                                n_state = ST_OUTW;
                            end else if (i_count > COUNT_W'(MAX_BATCH)) begin
                                n_ook   = 1'b0;
                                n_ovld  = 1'b1;
                                n_state = ST_OUTW;
                            end else begin
                                w_bc.op = OP_GSTART;
                                n_state = ST_SCAN;
                            end
                        end
                        CMD_DEL, CMD_VAL: begin
                            if (i_name == '0) begin
                                n_ovld  = 1'b1;
                                n_state = ST_OUTW;
                            end else begin
                                w_bc.op = OP_LOCATE;
                                w_bc.nm = i_name;
                                n_state = (i_cmd == CMD_DEL) ? ST_DRPT : ST_VRPT;
                            end
                        end
                        default: begin
                            n_ook   = 1'b0;
                            n_ovld  = 1'b1;
                            n_state = ST_OUTW;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                w_bc.op = OP_GSTEP;
                if (w_any.hit) begin
                    if (w_any.wrap) begin
                        n_ook   = 1'b0;
                        n_ovld  = 1'b1;
                        n_state = ST_OUTW;
                    end else begin
                        n_base  = w_any.fin;
                        n_merge = w_any.merge;
                        n_state = ST_GAPP;
                    end
                end
            end
            ST_GAPP: begin
                w_bc.op = r_merge ? OP_GMERGE : OP_GEXT;
                if (r_merge) n_cnt = r_cnt - CNT_W'(1);
                n_oname = r_base + 32'd1;
                n_left  = r_n - COUNT_W'(1);
                n_olast = (r_n == COUNT_W'(1));
                n_ovld  = 1'b1;
                n_state = ST_OUTW;
            end
            ST_DRPT: begin
                n_dfail = 1'b0;
                priority if (!w_any.tok) begin
                    n_dop = OP_NONE;
                end else if (w_any.single) begin
                    n_dop = OP_DREM;
                end else if (w_any.at_first) begin
                    n_dop = OP_DINC;
                end else if (w_any.at_final) begin
                    n_dop = OP_DDEC;
                end else if (r_cnt == CNT_W'(MAX_RANGES)) begin
                    n_dop   = OP_NONE;
                    n_dfail = 1'b1;
                end else begin
                    n_dop = OP_DSPLIT;
                end
                n_ofnd  = w_any.tok && !(r_cnt == CNT_W'(MAX_RANGES) && !w_any.single &&
                          !w_any.at_first && !w_any.at_final);
                n_state = ST_DAPP;
            end
            ST_DAPP: begin
                w_bc.op = r_dop;
                if (r_dop == OP_DREM) n_cnt = r_cnt - CNT_W'(1);
                if (r_dop == OP_DSPLIT) n_cnt = r_cnt + CNT_W'(1);
                n_ook   = !r_dfail;
                n_ovld  = 1'b1;
                n_state = ST_OUTW;
            end
            ST_VRPT: begin
                n_ofnd  = w_any.tok;
                n_ovld  = 1'b1;
                n_state = ST_OUTW;
            end
            ST_OUTW: begin
                if (i_ready) begin
                    if (r_olast) begin
                        n_ovld  = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_oname = r_oname + 32'd1;
                        n_left  = r_left - COUNT_W'(1);
                        n_olast = (r_left == COUNT_W'(1));
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= CNT_W'(1);
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_left  <= n_left;
        r_nm    <= n_nm;
        r_base  <= n_base;
        r_merge <= n_merge;
        r_dop   <= n_dop;
        r_dfail <= n_dfail;
        r_oname <= n_oname;
        r_ook   <= n_ook;
        r_ofnd  <= n_ofnd;
        r_olast <= n_olast;
    end

    `INA_ALWAYS(a_cnt_nonzero, r_cnt != '0)
    `INA_ALWAYS(a_head_valid, w_lnk[0].vld)
    `INA_ALWAYS(a_one_token, $onehot0(w_toks))
    `INA_IMPLY(a_ready_no_out, o_ready, !o_valid)

endmodule

### hdl/ina_cell.sv
// one cell of the range chain: holds at most one allocated range
// depends on ina_pkg
module ina_cell import ina_pkg::*; #(
    parameter bit P_HEAD = 1'b0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_bcast i_bc,
    input  t_link  i_left,
    input  t_link  i_right,
    output t_link  o_link,
    output t_rpt   o_rpt
);

    logic              r_vld, n_vld;
    logic              r_tok, n_tok;
    logic              r_passed, n_passed;
    logic [NAME_W-1:0] r_first, n_first;
    logic [NAME_W-1:0] r_final, n_final;

    logic [NAME_W:0]   w_sum;
    logic [NAME_W-1:0] w_grown, w_thr;
    logic              w_wrap, w_stop, w_merge, w_evt, w_after;

    assign w_sum   = {1'b0, r_final} + {{(NAME_W+1-COUNT_W){1'b0}}, i_bc.n};
    assign w_wrap  = w_sum[NAME_W];
    assign w_grown = w_sum[NAME_W-1:0];
    assign w_thr   = i_right.first - 32'd1;
    assign w_stop  = !i_right.vld || (w_grown < w_thr);
    assign w_merge = i_right.vld && (w_grown == w_thr);
    assign w_evt   = r_vld && (w_wrap || w_stop || w_merge);
    assign w_after = !r_tok && !r_passed;

    assign o_link = '{vld: r_vld, tok: r_tok, evt: w_evt, first: r_first, final_nm: r_final};

    assign o_rpt.tok      = r_tok;
    assign o_rpt.hit      = r_tok && w_evt;
    assign o_rpt.wrap     = r_tok && w_wrap;
    assign o_rpt.merge    = r_tok && !w_wrap && !w_stop && w_merge;
    assign o_rpt.single   = r_tok && (r_first == r_final);
    assign o_rpt.at_first = r_tok && (r_first == i_bc.nm);
    assign o_rpt.at_final = r_tok && (r_final == i_bc.nm);
    assign o_rpt.fin      = r_tok ? r_final : '0;

    always_comb begin
        n_vld    = r_vld;
        n_tok    = r_tok;
        n_passed = r_passed;
        n_first  = r_first;
        n_final  = r_final;
        unique case (i_bc.op)
            OP_GSTART: begin
                n_tok    = r_vld && !i_left.vld;
                n_passed = 1'b0;
            end
            OP_GSTEP: begin
                if (r_tok && !w_evt) begin
                    n_tok    = 1'b0;
                    n_passed = 1'b1;
                end else if (!r_tok && i_left.tok && !i_left.evt) begin
                    n_tok = 1'b1;
                end
            end
            OP_GEXT: begin
                if (r_tok) n_final = w_grown;
            end
            OP_GMERGE: begin
                if (r_tok) begin
                    n_final = i_right.final_nm;
                end else if (w_after) begin
                    n_vld   = i_right.vld;
                    n_first = i_right.first;
                    n_final = i_right.final_nm;
                end
            end
            OP_LOCATE: begin
                n_tok    = r_vld && (i_bc.nm >= r_first) && (i_bc.nm <= r_final);
                n_passed = r_vld && (r_final < i_bc.nm);
            end
            OP_DREM: begin
                if (r_tok || w_after) begin
                    n_vld   = i_right.vld;
                    n_first = i_right.first;
                    n_final = i_right.final_nm;
                end
            end
            OP_DINC: begin
                if (r_tok) n_first = r_first + 32'd1;
            end
            OP_DDEC: begin
                if (r_tok) n_final = r_final - 32'd1;
            end
            OP_DSPLIT: begin
                if (r_tok) begin
                    n_final = i_bc.nm - 32'd1;
                end else if (i_left.tok) begin
                    n_vld   = 1'b1;
                    n_first = i_bc.nm + 32'd1;
                    n_final = i_left.final_nm;
                end else if (w_after) begin
                    n_vld   = i_left.vld;
                    n_first = i_left.first;
                    n_final = i_left.final_nm;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= P_HEAD;
            r_tok    <= 1'b0;
            r_passed <= 1'b0;
            r_first  <= '0;
            r_final  <= '0;
        end else begin
            r_vld    <= n_vld;
            r_tok    <= n_tok;
            r_passed <= n_passed;
            r_first  <= n_first;
            r_final  <= n_final;
        end
    end

endmodule
